>>> design/dcpp_pkg.sv
// ----------------------------------------------------------------------------
// dcpp_pkg
// types, constants and tables shared by the pose predictor files
// ----------------------------------------------------------------------------
package dcpp_pkg;

	localparam int HIST_DEPTH   = 64;
	localparam int ADDR_W       = $clog2(HIST_DEPTH);
	localparam int CNT_W        = $clog2(HIST_DEPTH + 1);
	localparam int DELAY_W      = 6;
	localparam int INTERVAL_Q16 = 655;
	localparam int CORDIC_STEPS = 20;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] RAD_TO_TURN_Q32 = 32'd683565276;

	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

	typedef enum logic {
		CMD_PUSH    = 1'b0,
		CMD_PREDICT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FULL      = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_STOPPED   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_STEER    = 2'd0,
		CFG_THROTTLE = 2'd1,
		CFG_MODE     = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RDA,
		S_ACC,
		S_VUPD,
		S_CORD,
		S_MC,
		S_MCT,
		S_XUP,
		S_MST,
		S_YUP,
		S_KHI,
		S_KLO,
		S_DH,
		S_DK0,
		S_DK1,
		S_HUP,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] hist_curvature;
		logic signed [31:0] hist_accel;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [15:0] start_heading;
		logic signed [31:0] start_speed;
		logic signed [31:0] start_accel;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pred_x;
		logic signed [31:0] pred_y;
		logic signed [15:0] pred_heading;
		logic signed [31:0] pred_speed;
		logic signed [31:0] pred_accel;
		status_t            status;
	} rsp_t;

endpackage

>>> design/dcpp_ram.sv
// ----------------------------------------------------------------------------
// dcpp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module dcpp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/delay_compensated_pose_predictor_unit.sv
// ----------------------------------------------------------------------------
// delay_compensated_pose_predictor_unit
// command history ring and kinematic pose integration over the steering delay
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data (push or predict)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data (one per predict)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  push: written to the ring on accept. predict: each delay step runs the
//  20-step cordic and the shared multiplier sequence.
//  reset clears ring pointer, fill count, config registers and output valid.
//  req_stall is high while a predict runs or its result waits to load.
// ----------------------------------------------------------------------------
module delay_compensated_pose_predictor_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  dcpp_pkg::req_t        req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output dcpp_pkg::rsp_t        rsp_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [5:0]            cfg_data
);
	import dcpp_pkg::*;

	localparam logic signed [34:0] T_MUL = 35'(INTERVAL_Q16);
	localparam logic signed [34:0] K_MUL = 35'(RAD_TO_TURN_Q32);

	function automatic logic signed [31:0] sat32(input logic signed [71:0] s);
		if (s > 72'sh7FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end else if (s < -72'sh80000000) begin
			return 32'sh80000000;
		end
		return s[31:0];
	endfunction

	function automatic logic signed [71:0] ext32(input logic signed [31:0] a);
		return {{40{a[31]}}, a};
	endfunction

	function automatic logic signed [71:0] ext70(input logic signed [69:0] a);
		return {{2{a[69]}}, a};
	endfunction

	state_t state_q, state_d;

	logic [DELAY_W-1:0] steer_q, throttle_q, td;
	logic               mode_q;
	logic [ADDR_W-1:0]  wp_q;
	logic [CNT_W-1:0]   count_q;
	logic [DELAY_W-1:0] iter_q;
	logic [STEP_W-1:0]  k_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic signed [31:0] x_q, y_q, v_q, v0_q, acc_q, kappa_q;
	logic [15:0]        h_q;
	status_t            status_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic signed [69:0] prod_q;
	logic signed [34:0] mul_a, mul_b;
	logic signed [41:0] tmp_q;
	logic signed [42:0] dh_q;
	logic [47:0]        p1_q;
	logic [15:0]        qlo_q;

	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [63:0]        ram_rdata;

	logic               accept, not_ready, stop, out_free, last_iter;
	logic signed [31:0] vnew, acc_sel;
	logic signed [69:0] prod_sh30, prod_sh16;
	logic signed [33:0] cos_v, sin_v;
	logic [47:0]        hsum;
	logic [31:0]        turn;

	assign td        = (throttle_q > steer_q) ? throttle_q : steer_q;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign not_ready = (count_q <= CNT_W'(steer_q)) || (mode_q && (count_q <= CNT_W'(td)));
	assign last_iter = ({1'b0, iter_q} + 7'd1) == {1'b0, steer_q};

	assign prod_sh30 = prod_q >>> 30;
	assign prod_sh16 = prod_q >>> 16;
	assign vnew      = sat32(ext32(v_q) + ext70(prod_sh16));
	assign stop      = (v0_q == '0) || (vnew == '0) || (v0_q[31] != vnew[31]);
	assign cos_v     = flip_q ? -cx_q : cx_q;
	assign sin_v     = flip_q ? -cy_q : cy_q;
	assign hsum      = {prod_q[31:0], 16'b0} + p1_q;
	assign acc_sel   = mode_q ? $signed(ram_rdata[31:0]) : acc_q;
	assign turn      = {h_q[15] ^ (h_q[15] ^ h_q[14]), h_q[14:0], 16'b0};

	assign ram_we = accept && (req_data.cmd == CMD_PUSH);
	assign ram_re = (state_q == S_RDA) || (state_q == S_VUPD);
	always_comb begin
		ram_raddr = wp_q - ADDR_W'(td - iter_q);
		if (state_q == S_VUPD) begin
			ram_raddr = wp_q - ADDR_W'(steer_q - iter_q);
		end
	end

	dcpp_ram #(.WIDTH(64), .DEPTH(HIST_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata ({req_data.hist_curvature, req_data.hist_accel}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = T_MUL;
		unique case (state_q)
			S_ACC:  mul_a = 35'(acc_sel);
			S_MC: begin
				mul_a = 35'(v_q);
				mul_b = 35'(cos_v);
			end
			S_MCT:  mul_a = prod_sh30[34:0];
			S_XUP: begin
				mul_a = 35'(v_q);
				mul_b = 35'(sin_v);
			end
			S_MST:  mul_a = prod_sh30[34:0];
			S_YUP: begin
				mul_a = 35'(v_q);
				mul_b = 35'(kappa_q);
			end
			S_KHI:  mul_a = 35'($signed(prod_q[63:32]));
			S_KLO:  mul_a = {19'b0, qlo_q};
			S_DK0: begin
				mul_a = {19'b0, dh_q[15:0]};
				mul_b = K_MUL;
			end
			S_DK1: begin
				mul_a = 35'($signed(dh_q[42:16]));
				mul_b = K_MUL;
			end
			default: mul_a = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_data.cmd == CMD_PREDICT) begin
					state_d = (not_ready || steer_q == '0) ? S_DONE : S_RDA;
				end
			end
			S_RDA:  state_d = S_ACC;
			S_ACC:  state_d = S_VUPD;
			S_VUPD: state_d = stop ? S_DONE : S_CORD;
			S_CORD: begin
				if (k_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = S_MC;
				end
			end
			S_MC:   state_d = S_MCT;
			S_MCT:  state_d = S_XUP;
			S_XUP:  state_d = S_MST;
			S_MST:  state_d = S_YUP;
			S_YUP:  state_d = S_KHI;
			S_KHI:  state_d = S_KLO;
			S_KLO:  state_d = S_DH;
			S_DH:   state_d = S_DK0;
			S_DK0:  state_d = S_DK1;
			S_DK1:  state_d = S_HUP;
			S_HUP:  state_d = last_iter ? S_DONE : S_RDA;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_q     <= '0;
			throttle_q  <= '0;
			mode_q      <= 1'b0;
			wp_q        <= '0;
			count_q     <= '0;
			iter_q      <= '0;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_STEER:    steer_q    <= cfg_data[DELAY_W-1:0];
					CFG_THROTTLE: throttle_q <= cfg_data[DELAY_W-1:0];
					CFG_MODE:     mode_q     <= cfg_data[0];
					default:      mode_q     <= mode_q;
				endcase
			end
			if (ram_we) begin
				wp_q <= wp_q + 1'b1;
				if (count_q < CNT_W'(HIST_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (accept) begin
				iter_q <= '0;
			end else if (state_q == S_HUP) begin
				iter_q <= iter_q + 1'b1;
			end
			if (state_q == S_CORD) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				x_q      <= req_data.start_x;
				y_q      <= req_data.start_y;
				h_q      <= req_data.start_heading;
				v_q      <= req_data.start_speed;
				v0_q     <= req_data.start_speed;
				acc_q    <= req_data.start_accel;
				status_q <= not_ready ? ST_NOT_READY : ST_FULL;
			end
			S_VUPD: begin
				if (stop) begin
					v_q      <= '0;
					status_q <= ST_STOPPED;
				end else begin
					v_q <= vnew;
				end
				flip_q <= h_q[15] ^ h_q[14];
				cx_q   <= 34'(CORDIC_GAIN_Q30);
				cy_q   <= '0;
				cz_q   <= 34'($signed(turn));
			end
			S_CORD: begin
				if (k_q == '0) begin
					kappa_q <= $signed(ram_rdata[63:32]);
				end
				if (!cz_q[33]) begin
					cx_q <= cx_q - (cy_q >>> k_q);
					cy_q <= cy_q + (cx_q >>> k_q);
					cz_q <= cz_q - $signed({2'b0, ATAN_TURN[k_q]});
				end else begin
					cx_q <= cx_q + (cy_q >>> k_q);
					cy_q <= cy_q - (cx_q >>> k_q);
					cz_q <= cz_q + $signed({2'b0, ATAN_TURN[k_q]});
				end
			end
			S_XUP:  x_q   <= sat32(ext32(x_q) + ext70(prod_sh16));
			S_YUP:  y_q   <= sat32(ext32(y_q) + ext70(prod_sh16));
			S_KHI:  qlo_q <= prod_q[31:16];
			S_KLO:  tmp_q <= prod_q[41:0];
			S_DH:   dh_q  <= 43'(tmp_q) + 43'($signed({1'b0, prod_q[25:16]}));
			S_DK1:  p1_q  <= prod_q[47:0];
			S_HUP:  h_q   <= h_q + hsum[47:32];
			S_DONE: begin
				if (out_free) begin
					rsp_q.pred_x       <= x_q;
					rsp_q.pred_y       <= y_q;
					rsp_q.pred_heading <= h_q;
					rsp_q.pred_speed   <= v_q;
					rsp_q.pred_accel   <= acc_q;
					rsp_q.status       <= status_q;
				end
			end
			default: x_q <= x_q;
		endcase
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> req_stall)
		else $error("request taken while busy");

	a_stopped_speed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_STOPPED |-> rsp_data.pred_speed == '0)
		else $error("stopped result with nonzero speed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HIST_DEPTH))
		else $error("fill count beyond ring depth");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CORD |-> iter_q < steer_q)
		else $error("integration step beyond steering delay");

	a_push_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_data.cmd == CMD_PUSH |=> wp_q == $past(wp_q) + 1'b1)
		else $error("write pointer did not advance on push");

endmodule
